/* design/regrt_pkg.sv */
package regrt_pkg;

	localparam int DEF_SLOTS       = 16;
	localparam int DEF_COUNT_WIDTH = 16;

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_ACQUIRE    = 2'd2,
		OP_RELEASE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_FULL      = 2'd2,
		ST_REF_LIMIT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_WAIT,
		BK_FINISH
	} back_state_t;

	// classified command word passed from front to back
	typedef struct packed {
		op_t         op;
		logic [63:0] addr;
		logic [63:0] lim;
		logic        bad;
		logic [3:0]  rs;
	} cmd_t;

	// result word towards the ports
	typedef struct packed {
		logic        done;
		status_t     status;
		logic        registered;
		logic [3:0]  handle;
		logic        drained;
	} result_t;

endpackage

/* design/regrt_front.sv */
module regrt_front import regrt_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [1:0]  op,
	input  logic [63:0] addr,
	input  logic [63:0] length,
	input  logic [3:0]  release_slot,
	output logic        push,
	output cmd_t        cmd
);

	logic        v_s1;
	cmd_t        cmd_s1;
	logic [64:0] sum;
	logic        span_bad;
	logic        bad;

	// span check: zero address, zero length or end beyond 2^64 - 1
	assign sum      = {1'b0, addr} + {1'b0, length};
	assign span_bad = (addr == 64'd0) || (length == 64'd0) || sum[64];

	always_comb begin
		case (op_t'(op))
			OP_REGISTER:   bad = span_bad;
			OP_ACQUIRE:    bad = span_bad;
			OP_UNREGISTER: bad = (addr == 64'd0);
			OP_RELEASE:    bad = (32'(release_slot) >= 32'(SLOTS));
			default:       bad = 1'b1;
		endcase
	end

	// one classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op   <= op_t'(op);
			cmd_s1.addr <= addr;
			cmd_s1.lim  <= sum[63:0];
			cmd_s1.bad  <= bad;
			cmd_s1.rs   <= release_slot;
		end
	end

	assign push = v_s1;
	assign cmd  = cmd_s1;

endmodule

/* design/regrt_queue.sv */
module regrt_queue import regrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output logic valid,
	output cmd_t rd_cmd
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	// two-word queue between front and back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wr_cmd;
		end
	end

	assign valid  = (fill_q != 2'd0);
	assign rd_cmd = slot_q[rd_q];

endmodule

/* design/regrt_back.sv */
module regrt_back import regrt_pkg::*; #(
	parameter int SLOTS       = DEF_SLOTS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output logic    idle,
	output result_t res
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	back_state_t state_q, state_d;
	logic [SW-1:0] idx_q;
	logic          last_idx;
	cmd_t          cur_q;

	// interval memories, read one entry a cycle
	logic [63:0] base_mem [SLOTS];
	logic [63:0] lim_mem  [SLOTS];

	// per-slot control state
	logic                   used_q    [SLOTS];
	logic                   closing_q [SLOTS];
	logic [COUNT_WIDTH-1:0] cnt_q     [SLOTS];

	// scan stage
	logic                   v_s1;
	logic [SW-1:0]          idx_s1;
	logic [63:0]            base_s1;
	logic [63:0]            lim_s1;
	logic                   used_s1;
	logic                   closing_s1;
	logic [COUNT_WIDTH-1:0] cnt_s1;

	// scan findings
	logic                   found_q;
	logic [SW-1:0]          hit_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic                   hit_closing_q;
	logic                   clash_q;
	logic                   free_found_q;
	logic [SW-1:0]          free_q;

	logic    live_s1;
	logic    take_hit;
	result_t res_q;
	result_t fin;
	logic    do_alloc;
	logic    do_free;
	logic    do_close;
	logic    do_inc;
	logic    do_dec;

	assign last_idx = (idx_q == SW'(SLOTS - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (last_idx) begin
					state_d = BK_WAIT;
				end
			end
			BK_WAIT:   state_d = BK_FINISH;
			BK_FINISH: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	assign idle = (state_q == BK_IDLE);

	// registered read of one slot per cycle
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		idx_s1     <= idx_q;
		base_s1    <= base_mem[idx_q];
		lim_s1     <= lim_mem[idx_q];
		used_s1    <= used_q[idx_q];
		closing_s1 <= closing_q[idx_q];
		cnt_s1     <= cnt_q[idx_q];
		if (do_alloc) begin
			base_mem[free_q] <= cur_q.addr;
			lim_mem[free_q]  <= cur_q.lim;
		end
	end

	// per-entry match for the current operation
	assign live_s1 = used_s1 && !closing_s1;
	always_comb begin
		take_hit = 1'b0;
		case (cur_q.op)
			OP_UNREGISTER: take_hit = live_s1 && (base_s1 == cur_q.addr) && !found_q;
			OP_ACQUIRE:    take_hit = live_s1 && (base_s1 <= cur_q.addr) &&
				(cur_q.lim <= lim_s1) && !found_q;
			OP_RELEASE:    take_hit = (idx_s1 == SW'(cur_q.rs)) && used_s1 && !cur_q.bad;
			default:       take_hit = 1'b0;
		endcase
	end

	// final decision
	always_comb begin
		fin      = '0;
		fin.done = 1'b1;
		do_alloc = 1'b0;
		do_free  = 1'b0;
		do_close = 1'b0;
		do_inc   = 1'b0;
		do_dec   = 1'b0;
		case (cur_q.op)
			OP_REGISTER: begin
				if (cur_q.bad || clash_q) begin
					fin.status = ST_INVALID;
				end else if (!free_found_q) begin
					fin.status = ST_FULL;
				end else begin
					do_alloc = 1'b1;
				end
			end
			OP_UNREGISTER: begin
				if (cur_q.bad || !found_q) begin
					fin.status = ST_INVALID;
				end else if (hit_cnt_q == '0) begin
					do_free     = 1'b1;
					fin.drained = 1'b1;
					fin.handle  = 4'(hit_q);
				end else begin
					do_close = 1'b1;
				end
			end
			OP_ACQUIRE: begin
				if (cur_q.bad) begin
					fin.status = ST_INVALID;
				end else if (found_q) begin
					if (hit_cnt_q == CNT_MAX) begin
						fin.status = ST_REF_LIMIT;
					end else begin
						do_inc         = 1'b1;
						fin.registered = 1'b1;
						fin.handle     = 4'(hit_q);
					end
				end
			end
			OP_RELEASE: begin
				if (cur_q.bad || !found_q) begin
					fin.status = ST_INVALID;
				end else if (hit_cnt_q != '0) begin
					if (hit_cnt_q == CNT_ONE && hit_closing_q) begin
						do_free     = 1'b1;
						fin.drained = 1'b1;
						fin.handle  = 4'(hit_q);
					end else begin
						do_dec = 1'b1;
					end
				end
			end
			default: fin.status = ST_INVALID;
		endcase
		if (state_q != BK_FINISH) begin
			fin      = '0;
			do_alloc = 1'b0;
			do_free  = 1'b0;
			do_close = 1'b0;
			do_inc   = 1'b0;
			do_dec   = 1'b0;
		end
	end

	// scan bookkeeping, slot state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			v_s1          <= 1'b0;
			found_q       <= 1'b0;
			hit_q         <= '0;
			hit_cnt_q     <= '0;
			hit_closing_q <= 1'b0;
			clash_q       <= 1'b0;
			free_found_q  <= 1'b0;
			free_q        <= '0;
			res_q         <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				used_q[i]    <= 1'b0;
				closing_q[i] <= 1'b0;
				cnt_q[i]     <= '0;
			end
		end else begin
			v_s1  <= (state_q == BK_SCAN);
			res_q <= fin;
			if (cmd_pop) begin
				idx_q        <= '0;
				found_q      <= 1'b0;
				clash_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == BK_SCAN && !last_idx) begin
				idx_q <= idx_q + SW'(1);
			end
			if (v_s1) begin
				if (take_hit) begin
					found_q       <= 1'b1;
					hit_q         <= idx_s1;
					hit_cnt_q     <= cnt_s1;
					hit_closing_q <= closing_s1;
				end
				if (live_s1 && (base_s1 < cur_q.lim) && (lim_s1 > cur_q.addr)) begin
					clash_q <= 1'b1;
				end
				if (!used_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= idx_s1;
				end
			end
			if (do_alloc) begin
				used_q[free_q]    <= 1'b1;
				closing_q[free_q] <= 1'b0;
				cnt_q[free_q]     <= '0;
			end
			if (do_free) begin
				used_q[hit_q]    <= 1'b0;
				closing_q[hit_q] <= 1'b0;
				cnt_q[hit_q]     <= '0;
			end
			if (do_close) begin
				closing_q[hit_q] <= 1'b1;
			end
			if (do_inc) begin
				cnt_q[hit_q] <= hit_cnt_q + CNT_ONE;
			end
			if (do_dec) begin
				cnt_q[hit_q] <= hit_cnt_q - CNT_ONE;
			end
		end
	end

	assign res = res_q;

endmodule

/* design/region_registration_table.sv */
// channel   | ports                                   | handshake
// command   | op, addr, length, release_slot          | taken when start && !busy
// result    | status, registered, handle, drained     | one cycle, marked by done
//
// each word goes from start to done through the front stage, the queue and the
// back part, which reads one slot per cycle from the interval memory, then decides.
// busy stays high from the accepted word until its result is on the ports;
// the next word may be started in the cycle that shows the result.
// reset clears slot usage, closing marks and counts at once; no clearing pass.
// the receiver cannot stall, so done is never held.
module region_registration_table import regrt_pkg::*; #(
	parameter int SLOTS       = DEF_SLOTS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [63:0] addr,
	input  logic [63:0] length,
	input  logic [3:0]  release_slot,
	output logic        done,
	output logic [1:0]  status,
	output logic        registered,
	output logic [3:0]  handle,
	output logic        drained
);

	logic    take;
	logic    push;
	cmd_t    front_cmd;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    pop;
	logic    back_idle;
	result_t res;

	assign take = start && !busy;
	assign busy = push || q_valid || !back_idle;

	// front: span checks and classification
	regrt_front #(.SLOTS(SLOTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.op           (op),
		.addr         (addr),
		.length       (length),
		.release_slot (release_slot),
		.push         (push),
		.cmd          (front_cmd)
	);

	// short queue between the two halves
	regrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.valid  (q_valid),
		.rd_cmd (q_cmd)
	);

	// back: table scan and update
	regrt_back #(.SLOTS(SLOTS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (pop),
		.idle      (back_idle),
		.res       (res)
	);

	assign done       = res.done;
	assign status     = res.status;
	assign registered = res.registered;
	assign handle     = res.handle;
	assign drained    = res.drained;

	// checks
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(registered && drained)) else $error("registered and drained together");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (!registered && !drained))
		else $error("error result carries flags");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy) else $error("busy not raised after accepted word");
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (!registered && !drained)) else $error("flags without done");

endmodule
